### src/ppd_pkg.sv
`timescale 1ns / 1ps
package ppd_pkg;

  // Default image size in pixels
  localparam int unsigned DefImageWidth  = 1280;
  localparam int unsigned DefImageHeight = 720;

  // Reset values of the setup registers
  localparam logic [31:0] ResetFocal = 32'h0001_0000;

  // Signed 32-bit limits and one in Q8.24
  localparam logic signed [31:0] MaxS32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinS32 = 32'sh8000_0000;
  localparam logic signed [43:0] OneQ24 = 44'sd16777216;

  // Setup register indexes
  typedef enum logic [7:0] {
    CfgFocalX     = 8'd0,
    CfgFocalY     = 8'd1,
    CfgCenterX    = 8'd2,
    CfgCenterY    = 8'd3,
    CfgRadialK1   = 8'd4,
    CfgRadialK2   = 8'd5,
    CfgRadialK3   = 8'd6,
    CfgTangential = 8'd7
  } cfg_reg_e;

  // Camera-frame point word
  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
  } in_word_t;

  // Pixel word
  typedef struct packed {
    logic signed [15:0] pixel_col;
    logic signed [15:0] pixel_row;
    logic               in_image;
  } out_word_t;

endpackage

### src/ppd_div.sv
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider: x * 2^24 / z and y * 2^24 / z,
// truncated toward zero and saturated to signed 32 bits. One quotient bit
// per stage; both lanes share the divisor.
module ppd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] num_x_i,
  input  logic signed [31:0] num_y_i,
  input  logic signed [31:0] den_i,
  output logic               valid_o,
  output logic               pos_o,
  output logic signed [31:0] quot_x_o,
  output logic signed [31:0] quot_y_o
);

  localparam int unsigned Steps = 32;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [63:0] acc;
  } lane_t;

  typedef struct packed {
    logic        pos;
    logic [30:0] den;
    lane_t [1:0] lane;
  } div_stage_t;

  // Split off the sign, flag a quotient of 2^32 or more, place |num| << 24
  function automatic lane_t prep_lane(logic signed [31:0] num, logic [30:0] den);
    lane_t       l;
    logic [31:0] mag;
    mag   = num[31] ? (32'd0 - num) : num;
    l.neg = num[31];
    l.ovf = ({7'b0, mag} >= {den, 8'b0});
    l.acc = {8'b0, mag, 24'b0};
    return l;
  endfunction

  // One restoring step: shift remainder, try subtract, shift in quotient bit
  function automatic lane_t step_lane(lane_t l, logic [30:0] den);
    lane_t       n;
    logic [31:0] rem_sh;
    logic [32:0] diff;
    rem_sh = l.acc[62:31];
    diff   = {1'b0, rem_sh} - {2'b0, den};
    n      = l;
    if (diff[32]) begin
      n.acc = {rem_sh, l.acc[30:0], 1'b0};
    end else begin
      n.acc = {diff[31:0], l.acc[30:0], 1'b1};
    end
    return n;
  endfunction

  function automatic div_stage_t step_stage(div_stage_t s);
    div_stage_t n;
    n         = s;
    n.lane[0] = step_lane(s.lane[0], s.den);
    n.lane[1] = step_lane(s.lane[1], s.den);
    return n;
  endfunction

  // Apply sign and clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat_quot(lane_t l);
    logic [31:0] q;
    logic [31:0] res;
    q = l.acc[31:0];
    if (l.neg) begin
      res = (l.ovf || (q > 32'h8000_0000)) ? ppd_pkg::MinS32 : (32'd0 - q);
    end else begin
      res = (l.ovf || q[31]) ? ppd_pkg::MaxS32 : q;
    end
    return $signed(res);
  endfunction

  div_stage_t         pre_d;
  div_stage_t         stage_q [Steps+1];
  logic [Steps:0]     vld_q;
  logic               valid_q;
  logic               pos_q;
  logic signed [31:0] quot_x_q;
  logic signed [31:0] quot_y_q;

  // Prepare operands
  always_comb begin
    pre_d.pos     = !den_i[31] && (den_i != '0);
    pre_d.den     = den_i[30:0];
    pre_d.lane[0] = prep_lane(num_x_i, den_i[30:0]);
    pre_d.lane[1] = prep_lane(num_y_i, den_i[30:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= pre_d;
    end
  end

  // Advance one quotient bit per stage
  for (genvar k = 1; k <= Steps; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= step_stage(stage_q[k-1]);
      end
    end
  end

  // Saturate the quotients
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q    <= stage_q[Steps].pos;
      quot_x_q <= sat_quot(stage_q[Steps].lane[0]);
      quot_y_q <= sat_quot(stage_q[Steps].lane[1]);
    end
  end

  // Move valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[Steps-1:0], valid_i};
      valid_q <= vld_q[Steps];
    end
  end

  assign valid_o  = valid_q;
  assign pos_o    = pos_q;
  assign quot_x_o = quot_x_q;
  assign quot_y_o = quot_y_q;

endmodule

### src/point_projection_with_distortion_core.sv
`timescale 1ns / 1ps
// Pipeline: 47 register stages from the input word to the output word register.
// Throughput: one point per cycle; the 32-stage divider and the multiplier stages
// all advance together, so the whole pipeline holds only while the output word stalls.
// Reset: asynchronous, active low; clears all valid bits and loads the setup
// registers with unit focal lengths and zero offsets and distortion.
module point_projection_with_distortion_core #(
  parameter int unsigned IMAGE_WIDTH  = ppd_pkg::DefImageWidth,
  parameter int unsigned IMAGE_HEIGHT = ppd_pkg::DefImageHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ppd_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ppd_pkg::out_word_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam logic [15:0] ImgW = 16'(IMAGE_WIDTH);
  localparam logic [15:0] ImgH = 16'(IMAGE_HEIGHT);

  // Clamp a non-negative value to 2^31-1
  function automatic logic [30:0] cap31(logic [39:0] v);
    return (|v[39:31]) ? 31'h7FFF_FFFF : v[30:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [43:0] v);
    logic signed [31:0] res;
    if (v > 44'sd2147483647) begin
      res = ppd_pkg::MaxS32;
    end else if (v < -44'sd2147483648) begin
      res = ppd_pkg::MinS32;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [25:0] v);
    logic signed [15:0] res;
    if (v > 26'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -26'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // Setup registers
  logic [31:0]        focal_x_q, focal_y_q;
  logic signed [31:0] center_x_q, center_y_q;
  logic signed [31:0] k1_q, k2_q, k3_q;
  logic [63:0]        tang_q;
  logic signed [31:0] p1, p2;

  assign cfg_ready_o = 1'b1;
  assign p1          = $signed(tang_q[31:0]);
  assign p2          = $signed(tang_q[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= ppd_pkg::ResetFocal;
      focal_y_q  <= ppd_pkg::ResetFocal;
      center_x_q <= '0;
      center_y_q <= '0;
      k1_q       <= '0;
      k2_q       <= '0;
      k3_q       <= '0;
      tang_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (ppd_pkg::cfg_reg_e'(cfg_index_i))
        ppd_pkg::CfgFocalX:     focal_x_q  <= cfg_data_i[31:0];
        ppd_pkg::CfgFocalY:     focal_y_q  <= cfg_data_i[31:0];
        ppd_pkg::CfgCenterX:    center_x_q <= cfg_data_i[31:0];
        ppd_pkg::CfgCenterY:    center_y_q <= cfg_data_i[31:0];
        ppd_pkg::CfgRadialK1:   k1_q       <= cfg_data_i[31:0];
        ppd_pkg::CfgRadialK2:   k2_q       <= cfg_data_i[31:0];
        ppd_pkg::CfgRadialK3:   k3_q       <= cfg_data_i[31:0];
        ppd_pkg::CfgTangential: tang_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: hold everything only while the output word is stalled
  logic out_valid_q;
  logic en;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Normalize by depth
  logic               dv_valid, dv_pos;
  logic signed [31:0] dv_xn, dv_yn;

  ppd_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .num_x_i  (in_data_i.cam_x),
    .num_y_i  (in_data_i.cam_y),
    .den_i    (in_data_i.cam_z),
    .valid_o  (dv_valid),
    .pos_o    (dv_pos),
    .quot_x_o (dv_xn),
    .quot_y_o (dv_yn)
  );

  // Stage registers
  logic [12:1] vld_q;

  logic               s1_pos_q;
  logic signed [31:0] s1_xn_q, s1_yn_q;
  logic [62:0]        s1_sqx_q, s1_sqy_q;
  logic signed [63:0] s1_pxy_q;

  logic               s2_pos_q;
  logic signed [31:0] s2_xn_q, s2_yn_q, s2_xy_q;
  logic [30:0]        s2_xx_q, s2_yy_q, s2_r_q;

  logic               s3_pos_q;
  logic signed [31:0] s3_xn_q, s3_yn_q, s3_xy_q;
  logic [30:0]        s3_r_q, s3_ex_q, s3_ey_q;
  logic [61:0]        s3_rr_q;
  logic signed [63:0] s3_k1r_q;

  logic               s4_pos_q;
  logic signed [31:0] s4_xn_q, s4_yn_q, s4_xy_q;
  logic [30:0]        s4_r_q, s4_r2_q, s4_ex_q, s4_ey_q;
  logic signed [63:0] s4_k1r_q;

  logic               s5_pos_q;
  logic signed [31:0] s5_xn_q, s5_yn_q, s5_xy_q;
  logic [30:0]        s5_ex_q, s5_ey_q;
  logic [61:0]        s5_r2r_q;
  logic signed [63:0] s5_k1r_q, s5_k2r2_q;

  logic               s6_pos_q;
  logic signed [31:0] s6_xn_q, s6_yn_q, s6_xy_q;
  logic [30:0]        s6_r3_q, s6_ex_q, s6_ey_q;
  logic signed [63:0] s6_k1r_q, s6_k2r2_q;

  logic               s7_pos_q;
  logic signed [31:0] s7_xn_q, s7_yn_q, s7_xy_q;
  logic [30:0]        s7_ex_q, s7_ey_q;
  logic signed [63:0] s7_k1r_q, s7_k2r2_q, s7_k3r3_q;

  logic               s8_pos_q;
  logic signed [31:0] s8_xn_q, s8_yn_q, s8_xy_q, s8_rad_q;
  logic [30:0]        s8_ex_q, s8_ey_q;

  logic               s9_pos_q;
  logic signed [63:0] s9_xrad_q, s9_yrad_q, s9_p1xy_q, s9_p2ex_q, s9_p1ey_q, s9_p2xy_q;

  logic               s10_pos_q;
  logic signed [31:0] s10_xd_q, s10_yd_q;

  logic               s11_pos_q;
  logic signed [64:0] s11_fxd_q, s11_fyd_q;

  logic               s12_pos_q;
  logic signed [41:0] s12_u_q, s12_v_q;

  ppd_pkg::out_word_t out_q;

  // Multipliers, one register stage after each
  logic signed [63:0] m_xx, m_yy, m_xy;
  logic [61:0]        m_rr, m_r2r;
  logic signed [63:0] m_k1r, m_k2r2, m_k3r3;
  logic signed [63:0] m_xrad, m_yrad, m_p1xy, m_p2ex, m_p1ey, m_p2xy;
  logic signed [64:0] m_fxd, m_fyd;

  assign m_xx   = dv_xn * dv_xn;
  assign m_yy   = dv_yn * dv_yn;
  assign m_xy   = dv_xn * dv_yn;
  assign m_rr   = s2_r_q * s2_r_q;
  assign m_k1r  = k1_q * $signed({1'b0, s2_r_q});
  assign m_r2r  = s4_r2_q * s4_r_q;
  assign m_k2r2 = k2_q * $signed({1'b0, s4_r2_q});
  assign m_k3r3 = k3_q * $signed({1'b0, s6_r3_q});
  assign m_xrad = s8_xn_q * s8_rad_q;
  assign m_yrad = s8_yn_q * s8_rad_q;
  assign m_p1xy = p1 * s8_xy_q;
  assign m_p2ex = p2 * $signed({1'b0, s8_ex_q});
  assign m_p1ey = p1 * $signed({1'b0, s8_ey_q});
  assign m_p2xy = p2 * s8_xy_q;
  assign m_fxd  = $signed({1'b0, focal_x_q}) * s10_xd_q;
  assign m_fyd  = $signed({1'b0, focal_y_q}) * s10_yd_q;

  // Shift, clamp and sum between the multiplier stages
  logic [63:0]        s2_sum;
  logic [30:0]        s2_xx_d, s2_yy_d, s2_r_d;
  logic signed [31:0] s2_xy_d;
  logic [30:0]        s3_ex_d, s3_ey_d;
  logic [30:0]        s4_r2_d, s6_r3_d;
  logic signed [43:0] rad_sum, xd_sum, yd_sum;
  logic signed [41:0] s12_u_d, s12_v_d;
  logic signed [41:0] ub, vb;
  logic signed [15:0] col, row;
  logic               in_img;
  ppd_pkg::out_word_t out_d;

  always_comb begin
    s2_sum  = {1'b0, s1_sqx_q} + {1'b0, s1_sqy_q};
    s2_xx_d = cap31({1'b0, s1_sqx_q[62:24]});
    s2_yy_d = cap31({1'b0, s1_sqy_q[62:24]});
    s2_r_d  = cap31(s2_sum[63:24]);
    s2_xy_d = sat32(44'($signed(s1_pxy_q[63:24])));

    s3_ex_d = cap31({9'b0, s2_r_q} + {8'b0, s2_xx_q, 1'b0});
    s3_ey_d = cap31({9'b0, s2_r_q} + {8'b0, s2_yy_q, 1'b0});

    s4_r2_d = cap31({2'b0, s3_rr_q[61:24]});
    s6_r3_d = cap31({2'b0, s5_r2r_q[61:24]});

    rad_sum = ppd_pkg::OneQ24 + 44'($signed(s7_k1r_q[63:24]))
            + 44'($signed(s7_k2r2_q[63:24])) + 44'($signed(s7_k3r3_q[63:24]));

    xd_sum = 44'($signed(s9_xrad_q[63:24])) + 44'($signed(s9_p1xy_q[63:23]))
           + 44'($signed(s9_p2ex_q[63:24]));
    yd_sum = 44'($signed(s9_yrad_q[63:24])) + 44'($signed(s9_p1ey_q[63:24]))
           + 44'($signed(s9_p2xy_q[63:23]));

    s12_u_d = 42'($signed(s11_fxd_q[64:24])) + 42'(center_x_q);
    s12_v_d = 42'($signed(s11_fyd_q[64:24])) + 42'(center_y_q);

    // Truncate toward zero: bias negative values before the shift
    ub  = s12_u_q + (s12_u_q[41] ? 42'sd65535 : 42'sd0);
    vb  = s12_v_q + (s12_v_q[41] ? 42'sd65535 : 42'sd0);
    col = sat16($signed(ub[41:16]));
    row = sat16($signed(vb[41:16]));

    in_img = !col[15] && ({1'b0, col[14:0]} < ImgW)
          && !row[15] && ({1'b0, row[14:0]} < ImgH);

    // Zero the pixel and clear in_image for points at or behind the camera plane
    out_d.pixel_col = s12_pos_q ? col : '0;
    out_d.pixel_row = s12_pos_q ? row : '0;
    out_d.in_image  = s12_pos_q && in_img;
  end

  // Advance the data path
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pos_q  <= dv_pos;
      s1_xn_q   <= dv_xn;
      s1_yn_q   <= dv_yn;
      s1_sqx_q  <= m_xx[62:0];
      s1_sqy_q  <= m_yy[62:0];
      s1_pxy_q  <= m_xy;

      s2_pos_q  <= s1_pos_q;
      s2_xn_q   <= s1_xn_q;
      s2_yn_q   <= s1_yn_q;
      s2_xy_q   <= s2_xy_d;
      s2_xx_q   <= s2_xx_d;
      s2_yy_q   <= s2_yy_d;
      s2_r_q    <= s2_r_d;

      s3_pos_q  <= s2_pos_q;
      s3_xn_q   <= s2_xn_q;
      s3_yn_q   <= s2_yn_q;
      s3_xy_q   <= s2_xy_q;
      s3_r_q    <= s2_r_q;
      s3_rr_q   <= m_rr;
      s3_ex_q   <= s3_ex_d;
      s3_ey_q   <= s3_ey_d;
      s3_k1r_q  <= m_k1r;

      s4_pos_q  <= s3_pos_q;
      s4_xn_q   <= s3_xn_q;
      s4_yn_q   <= s3_yn_q;
      s4_xy_q   <= s3_xy_q;
      s4_r_q    <= s3_r_q;
      s4_r2_q   <= s4_r2_d;
      s4_ex_q   <= s3_ex_q;
      s4_ey_q   <= s3_ey_q;
      s4_k1r_q  <= s3_k1r_q;

      s5_pos_q  <= s4_pos_q;
      s5_xn_q   <= s4_xn_q;
      s5_yn_q   <= s4_yn_q;
      s5_xy_q   <= s4_xy_q;
      s5_ex_q   <= s4_ex_q;
      s5_ey_q   <= s4_ey_q;
      s5_r2r_q  <= m_r2r;
      s5_k1r_q  <= s4_k1r_q;
      s5_k2r2_q <= m_k2r2;

      s6_pos_q  <= s5_pos_q;
      s6_xn_q   <= s5_xn_q;
      s6_yn_q   <= s5_yn_q;
      s6_xy_q   <= s5_xy_q;
      s6_r3_q   <= s6_r3_d;
      s6_ex_q   <= s5_ex_q;
      s6_ey_q   <= s5_ey_q;
      s6_k1r_q  <= s5_k1r_q;
      s6_k2r2_q <= s5_k2r2_q;

      s7_pos_q  <= s6_pos_q;
      s7_xn_q   <= s6_xn_q;
      s7_yn_q   <= s6_yn_q;
      s7_xy_q   <= s6_xy_q;
      s7_ex_q   <= s6_ex_q;
      s7_ey_q   <= s6_ey_q;
      s7_k1r_q  <= s6_k1r_q;
      s7_k2r2_q <= s6_k2r2_q;
      s7_k3r3_q <= m_k3r3;

      s8_pos_q  <= s7_pos_q;
      s8_xn_q   <= s7_xn_q;
      s8_yn_q   <= s7_yn_q;
      s8_xy_q   <= s7_xy_q;
      s8_ex_q   <= s7_ex_q;
      s8_ey_q   <= s7_ey_q;
      s8_rad_q  <= sat32(rad_sum);

      s9_pos_q  <= s8_pos_q;
      s9_xrad_q <= m_xrad;
      s9_yrad_q <= m_yrad;
      s9_p1xy_q <= m_p1xy;
      s9_p2ex_q <= m_p2ex;
      s9_p1ey_q <= m_p1ey;
      s9_p2xy_q <= m_p2xy;

      s10_pos_q <= s9_pos_q;
      s10_xd_q  <= sat32(xd_sum);
      s10_yd_q  <= sat32(yd_sum);

      s11_pos_q <= s10_pos_q;
      s11_fxd_q <= m_fxd;
      s11_fyd_q <= m_fyd;

      s12_pos_q <= s11_pos_q;
      s12_u_q   <= s12_u_d;
      s12_v_q   <= s12_v_d;

      out_q     <= out_d;
    end
  end

  // Move valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[11:1], dv_valid};
      out_valid_q <= vld_q[12];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
